// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, clocked on clock, off during reset
`define MAE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define MAE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== sv/mae_pkg.sv =====
package mae_pkg;

   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 16;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int CD_W      = $clog2(MAX_DIM + 1);
   localparam int NA_W      = $clog2(DEPTH + 1);
   localparam int LC_W      = $clog2(2 * DEPTH + 1);
   localparam int ACC_W     = 64 + IDX_W + 1;
   localparam int NUM_W     = 32 + FRAC_BITS;

   localparam logic [2:0] OP_MUL  = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_ADDS = 3'd3;
   localparam logic [2:0] OP_SUBS = 3'd4;
   localparam logic [2:0] OP_MULS = 3'd5;
   localparam logic [2:0] OP_DIVS = 3'd6;
   localparam logic [2:0] OP_TRAN = 3'd7;

   localparam logic [2:0] REG_OPERATION = 3'd0;
   localparam logic [2:0] REG_ROWS_A    = 3'd1;
   localparam logic [2:0] REG_COLS_A    = 3'd2;
   localparam logic [2:0] REG_ROWS_B    = 3'd3;
   localparam logic [2:0] REG_COLS_B    = 3'd4;
   localparam logic [2:0] REG_SCALAR    = 3'd5;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
   localparam logic [1:0] STATUS_DIVZERO  = 2'd3;

   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   typedef struct packed {
      logic        valid;
      logic [31:0] value;
      logic        last;
      logic [1:0]  status;
   } result_type;

   function automatic logic [CD_W-1:0] clamp_dim(input logic [3:0] d);
      if (d == 4'd0) return CD_W'(1);
      if (int'(d) > MAX_DIM) return CD_W'(MAX_DIM);
      return CD_W'(d);
   endfunction

endpackage

// ===== sv/mae_ram.sv =====
module mae_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/mae_div.sv =====
module mae_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  dividend,
   input  logic signed [31:0]  divisor,
   input  logic                last_in,
   output mae_pkg::result_type result
);

   localparam int CNT_W = $clog2(mae_pkg::NUM_W);

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [mae_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [31:0]                   rem_ff, rem_in;
   logic [31:0]                   den_ff, den_in;
   logic                          neg_ff, neg_in;
   logic                          last_ff, last_in_q;
   mae_pkg::result_type           res_ff, res_in;

   logic [31:0]                   abs_num, abs_den;
   logic [32:0]                   rem_sh;
   logic                          qbit;
   logic [mae_pkg::NUM_W:0]       q_ext;

   assign abs_num = dividend[31] ? 32'(-dividend) : dividend;
   assign abs_den = divisor[31] ? 32'(-divisor) : divisor;
   assign rem_sh  = {rem_ff, num_ff[mae_pkg::NUM_W-1]};
   assign qbit    = rem_sh >= {1'b0, den_ff};
   assign q_ext   = {1'b0, num_ff};

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      last_in_q = last_ff;
      res_in    = '0;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               last_in_q = last_in;
               if (divisor == 32'sd0) begin
                  res_in.valid  = 1'b1;
                  res_in.value  = dividend[31] ? mae_pkg::Q_MIN : mae_pkg::Q_MAX;
                  res_in.last   = last_in;
                  res_in.status = mae_pkg::STATUS_DIVZERO;
               end else begin
                  num_in   = mae_pkg::NUM_W'(abs_num) << mae_pkg::FRAC_BITS;
                  den_in   = abs_den;
                  rem_in   = '0;
                  neg_in   = dividend[31] ^ divisor[31];
                  cnt_in   = '0;
                  state_in = D_RUN;
               end
            end
         end
         D_RUN: begin
            rem_in = qbit ? 32'(rem_sh - {1'b0, den_ff}) : rem_sh[31:0];
            num_in = {num_ff[mae_pkg::NUM_W-2:0], qbit};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(mae_pkg::NUM_W - 1)) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            res_in.valid  = 1'b1;
            res_in.last   = last_ff;
            res_in.status = mae_pkg::STATUS_OK;
            if (neg_ff) begin
               if (q_ext > (mae_pkg::NUM_W+1)'(64'h8000_0000)) begin
                  res_in.value  = mae_pkg::Q_MIN;
                  res_in.status = mae_pkg::STATUS_OVERFLOW;
               end else begin
                  res_in.value = 32'(-num_ff);
               end
            end else begin
               if (q_ext > (mae_pkg::NUM_W+1)'(64'h7FFF_FFFF)) begin
                  res_in.value  = mae_pkg::Q_MAX;
                  res_in.status = mae_pkg::STATUS_OVERFLOW;
               end else begin
                  res_in.value = num_ff[31:0];
               end
            end
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= D_IDLE;
         res_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_ff.valid <= res_in.valid;
      end
      res_ff.value  <= res_in.value;
      res_ff.last   <= res_in.last;
      res_ff.status <= res_in.status;
      cnt_ff        <= cnt_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      neg_ff        <= neg_in;
      last_ff       <= last_in_q;
   end

   assign result = res_ff;

endmodule

// ===== sv/matrix_arithmetic_engine.sv =====
// Loading: one operand beat per cycle while busy is low; busy rises after the last operand beat.
// Multiply: each result is the sum of cols_a products, accumulated one after another.
// Elementwise, scalar add/sub/mul and transpose ops: one result per cycle.
// Divide by scalar: one element at a time, 48-step shift-subtract divider, skipped if s is 0.
// Dimension mismatch: a single error beat after the last operand beat, via the S_ERR state.
// Synchronous reset restores register defaults and clears the load count; results cannot stall.
`include "assert_macros.svh"
module matrix_arithmetic_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_element,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_result_element,
   output logic               rsp_last_result,
   output logic [1:0]         rsp_status,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   localparam int AW = mae_pkg::ADDR_W;
   localparam int IW = mae_pkg::IDX_W;
   localparam int CW = mae_pkg::CD_W;

   typedef enum logic [1:0] {S_LOAD, S_ERR, S_RUN, S_DRAIN} state_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last_k;
      logic last_el;
   } token_type;

   logic [2:0]         op_ff;
   logic [3:0]         rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic signed [31:0] scalar_ff;

   state_type               state_ff, state_in;
   logic [mae_pkg::LC_W-1:0] load_ff, load_in;
   logic [IW-1:0]           r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic                    div_wait_ff, div_wait_in;
   logic                    strobe_ff;
   logic [31:0]             value_ff;
   logic                    last_ff;
   logic [1:0]              status_ff;
   mae_pkg::result_type     out_in;

   logic [CW-1:0]              ra, ca, rb, cb, orows, ocols, kmax;
   logic [mae_pkg::NA_W-1:0]   na, nb;
   logic [mae_pkg::LC_W-1:0]   total, load_off;
   logic                       accept, last_load, mismatch, is_mul, issue;
   logic                       r_end, c_end, k_end;
   logic                       wr_a, wr_b;
   logic [AW-1:0]              a_addr, b_addr;
   logic signed [31:0]         a_rd, b_rd;

   token_type                  t1_ff, t2_ff, t3_ff, tok0;
   logic signed [63:0]         prod_ff, prod_in;
   logic signed [32:0]         lin_ff, lin_in, lin3_ff;
   logic signed [mae_pkg::ACC_W-1:0] acc_ff, acc_in, acc_sh;
   logic signed [31:0]         mul_b;
   mae_pkg::result_type        div_res;
   logic                       acc_ovf;

   assign ra = mae_pkg::clamp_dim(rows_a_ff);
   assign ca = mae_pkg::clamp_dim(cols_a_ff);
   assign rb = mae_pkg::clamp_dim(rows_b_ff);
   assign cb = mae_pkg::clamp_dim(cols_b_ff);
   assign na = mae_pkg::NA_W'(ra) * mae_pkg::NA_W'(ca);
   assign nb = mae_pkg::NA_W'(rb) * mae_pkg::NA_W'(cb);
   assign total = (op_ff <= mae_pkg::OP_SUB) ? mae_pkg::LC_W'(na) + mae_pkg::LC_W'(nb)
                                            : mae_pkg::LC_W'(na);
   assign is_mul = op_ff == mae_pkg::OP_MUL;
   assign orows  = (op_ff == mae_pkg::OP_TRAN) ? ca : ra;
   assign ocols  = is_mul ? cb : ((op_ff == mae_pkg::OP_TRAN) ? ra : ca);
   assign kmax   = is_mul ? ca : CW'(1);

   always_comb begin
      mismatch = 1'b0;
      if (is_mul && ca != rb) mismatch = 1'b1;
      if ((op_ff == mae_pkg::OP_ADD || op_ff == mae_pkg::OP_SUB) && (ra != rb || ca != cb)) begin
         mismatch = 1'b1;
      end
   end

   assign busy      = state_ff != S_LOAD;
   assign accept    = start && !busy;
   assign load_off  = load_ff - mae_pkg::LC_W'(na);
   assign wr_a      = accept && load_ff < mae_pkg::LC_W'(na);
   assign wr_b      = accept && !(load_ff < mae_pkg::LC_W'(na)) && load_off < mae_pkg::LC_W'(nb);
   assign last_load = accept && (load_ff + mae_pkg::LC_W'(1)) >= total;

   assign issue = state_ff == S_RUN && !(op_ff == mae_pkg::OP_DIVS && div_wait_ff);
   assign k_end = CW'(k_ff) == kmax - CW'(1);
   assign c_end = CW'(c_ff) == ocols - CW'(1);
   assign r_end = CW'(r_ff) == orows - CW'(1);

   always_comb begin
      if (is_mul) begin
         a_addr = AW'(r_ff) * AW'(ca) + AW'(k_ff);
         b_addr = AW'(k_ff) * AW'(cb) + AW'(c_ff);
      end else if (op_ff == mae_pkg::OP_TRAN) begin
         a_addr = AW'(c_ff) * AW'(ca) + AW'(r_ff);
         b_addr = a_addr;
      end else begin
         a_addr = AW'(r_ff) * AW'(ca) + AW'(c_ff);
         b_addr = a_addr;
      end
   end

   mae_ram #(.WIDTH(32), .DEPTH(mae_pkg::DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (load_ff[AW-1:0]),
      .wr_data (req_element),
      .rd_addr (a_addr),
      .rd_data (a_rd)
   );

   mae_ram #(.WIDTH(32), .DEPTH(mae_pkg::DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (load_off[AW-1:0]),
      .wr_data (req_element),
      .rd_addr (b_addr),
      .rd_data (b_rd)
   );

   mae_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (t1_ff.valid && op_ff == mae_pkg::OP_DIVS),
      .dividend (a_rd),
      .divisor  (scalar_ff),
      .last_in  (t1_ff.last_el),
      .result   (div_res)
   );

   assign tok0.valid   = issue;
   assign tok0.first   = k_ff == '0;
   assign tok0.last_k  = k_end;
   assign tok0.last_el = k_end && c_end && r_end;

   assign mul_b   = is_mul ? b_rd : scalar_ff;
   assign prod_in = a_rd * mul_b;

   always_comb begin
      case (op_ff)
         mae_pkg::OP_ADD:  lin_in = {a_rd[31], a_rd} + {b_rd[31], b_rd};
         mae_pkg::OP_SUB:  lin_in = {a_rd[31], a_rd} - {b_rd[31], b_rd};
         mae_pkg::OP_ADDS: lin_in = {a_rd[31], a_rd} + {scalar_ff[31], scalar_ff};
         mae_pkg::OP_SUBS: lin_in = {a_rd[31], a_rd} - {scalar_ff[31], scalar_ff};
         default:          lin_in = {a_rd[31], a_rd};
      endcase
   end

   assign acc_in  = t2_ff.first ? mae_pkg::ACC_W'(prod_ff) : acc_ff + mae_pkg::ACC_W'(prod_ff);
   assign acc_sh  = acc_ff >>> mae_pkg::FRAC_BITS;
   assign acc_ovf = !((&acc_sh[mae_pkg::ACC_W-1:31]) || !(|acc_sh[mae_pkg::ACC_W-1:31]));

   always_comb begin
      out_in = '0;
      if (state_ff == S_ERR) begin
         out_in.valid  = 1'b1;
         out_in.last   = 1'b1;
         out_in.status = mae_pkg::STATUS_MISMATCH;
      end else if (div_res.valid) begin
         out_in = div_res;
      end else if (t3_ff.valid && t3_ff.last_k && op_ff != mae_pkg::OP_DIVS) begin
         out_in.valid  = 1'b1;
         out_in.last   = t3_ff.last_el;
         out_in.status = mae_pkg::STATUS_OK;
         if (is_mul || op_ff == mae_pkg::OP_MULS) begin
            if (acc_ovf) begin
               out_in.value  = acc_sh[mae_pkg::ACC_W-1] ? mae_pkg::Q_MIN : mae_pkg::Q_MAX;
               out_in.status = mae_pkg::STATUS_OVERFLOW;
            end else begin
               out_in.value = acc_sh[31:0];
            end
         end else if (lin3_ff[32] != lin3_ff[31]) begin
            out_in.value  = lin3_ff[32] ? mae_pkg::Q_MIN : mae_pkg::Q_MAX;
            out_in.status = mae_pkg::STATUS_OVERFLOW;
         end else begin
            out_in.value = lin3_ff[31:0];
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      load_in     = load_ff;
      r_in        = r_ff;
      c_in        = c_ff;
      k_in        = k_ff;
      div_wait_in = div_wait_ff;
      if (div_res.valid) begin
         div_wait_in = 1'b0;
      end else if (issue && op_ff == mae_pkg::OP_DIVS) begin
         div_wait_in = 1'b1;
      end
      if (csr_write_enable && csr_index <= mae_pkg::REG_SCALAR) begin
         load_in = '0;
      end else if (accept) begin
         load_in = last_load ? '0 : load_ff + mae_pkg::LC_W'(1);
      end
      case (state_ff)
         S_LOAD: begin
            if (last_load) begin
               state_in = mismatch ? S_ERR : S_RUN;
               r_in     = '0;
               c_in     = '0;
               k_in     = '0;
            end
         end
         S_ERR: state_in = S_LOAD;
         S_RUN: begin
            if (issue) begin
               if (k_end) begin
                  k_in = '0;
                  if (c_end) begin
                     c_in = '0;
                     r_in = r_ff + IW'(1);
                  end else begin
                     c_in = c_ff + IW'(1);
                  end
               end else begin
                  k_in = k_ff + IW'(1);
               end
               if (tok0.last_el) state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (out_in.valid && out_in.last) state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         load_ff     <= '0;
         div_wait_ff <= 1'b0;
         strobe_ff   <= 1'b0;
         op_ff       <= mae_pkg::OP_MUL;
         rows_a_ff   <= 4'd1;
         cols_a_ff   <= 4'd1;
         rows_b_ff   <= 4'd1;
         cols_b_ff   <= 4'd1;
         scalar_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         load_ff     <= load_in;
         div_wait_ff <= div_wait_in;
         strobe_ff   <= out_in.valid;
         if (csr_write_enable) begin
            case (csr_index)
               mae_pkg::REG_OPERATION: op_ff     <= csr_write_data[2:0];
               mae_pkg::REG_ROWS_A:    rows_a_ff <= csr_write_data[3:0];
               mae_pkg::REG_COLS_A:    cols_a_ff <= csr_write_data[3:0];
               mae_pkg::REG_ROWS_B:    rows_b_ff <= csr_write_data[3:0];
               mae_pkg::REG_COLS_B:    cols_b_ff <= csr_write_data[3:0];
               mae_pkg::REG_SCALAR:    scalar_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
      r_ff      <= r_in;
      c_ff      <= c_in;
      k_ff      <= k_in;
      value_ff  <= out_in.value;
      last_ff   <= out_in.last;
      status_ff <= out_in.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
      end else begin
         t1_ff <= tok0;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
      end
      prod_ff <= prod_in;
      lin_ff  <= lin_in;
      acc_ff  <= acc_in;
      lin3_ff <= lin_ff;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_result_element = value_ff;
   assign rsp_last_result    = last_ff;
   assign rsp_status         = status_ff;

   `MAE_ASSERT_IMP(a_last_frees, rsp_strobe && rsp_last_result, !busy, "busy after last beat")
   `MAE_ASSERT_IMP(a_err_last, rsp_strobe && rsp_status == mae_pkg::STATUS_MISMATCH, rsp_last_result, "mismatch beat not last")
   `MAE_ASSERT_NXT(a_div_clear, div_res.valid, !div_wait_ff, "divider wait not cleared")

endmodule

// ===== tb/result_checker.sv =====
module result_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_element,
   input  logic               rsp_strobe,
   input  logic signed [31:0] rsp_result_element,
   input  logic               rsp_last_result,
   input  logic [1:0]         rsp_status,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      logic signed [31:0] value;
      logic               last;
      logic [1:0]         status;
   } elem_beat_type;

   elem_beat_type result_fifo[$];

   logic [2:0]         op_reg;
   logic [3:0]         ra_reg, ca_reg, rb_reg, cb_reg;
   logic signed [31:0] scalar_reg;
   logic signed [31:0] a_mat[mae_pkg::DEPTH];
   logic signed [31:0] b_mat[mae_pkg::DEPTH];
   int                 loaded;

   function automatic int dim_of(input logic [3:0] d);
      if (d == 0) return 1;
      if (d > mae_pkg::MAX_DIM) return mae_pkg::MAX_DIM;
      return int'(d);
   endfunction

   function automatic logic signed [31:0] saturate(input logic signed [127:0] v,
                                                   inout logic ovf);
      if (v > 128'sh7FFF_FFFF) begin
         ovf = 1'b1;
         return mae_pkg::Q_MAX;
      end
      if (v < -128'sh8000_0000) begin
         ovf = 1'b1;
         return mae_pkg::Q_MIN;
      end
      return v[31:0];
   endfunction

   task automatic push_results();
      int ra, ca, rb, cb, orows, ocols, cnt;
      logic signed [127:0] acc;
      longint a, s;
      logic ovf;
      elem_beat_type e;
      ra = dim_of(ra_reg); ca = dim_of(ca_reg);
      rb = dim_of(rb_reg); cb = dim_of(cb_reg);
      if ((op_reg == mae_pkg::OP_MUL && ca != rb) ||
          ((op_reg == mae_pkg::OP_ADD || op_reg == mae_pkg::OP_SUB) &&
           (ra != rb || ca != cb))) begin
         e.value = 0; e.last = 1'b1; e.status = mae_pkg::STATUS_MISMATCH;
         result_fifo.push_back(e);
         return;
      end
      orows = ra; ocols = ca;
      if (op_reg == mae_pkg::OP_MUL) ocols = cb;
      if (op_reg == mae_pkg::OP_TRAN) begin
         orows = ca; ocols = ra;
      end
      cnt = 0;
      s = scalar_reg;
      for (int r = 0; r < orows; r++) begin
         for (int c = 0; c < ocols; c++) begin
            ovf = 1'b0;
            e.status = mae_pkg::STATUS_OK;
            a = (op_reg == mae_pkg::OP_TRAN) ? a_mat[c * ca + r]
                                             : a_mat[(r * ca + c) % mae_pkg::DEPTH];
            case (op_reg)
               mae_pkg::OP_MUL: begin
                  acc = 0;
                  for (int k = 0; k < ca; k++)
                     acc += 128'(longint'(a_mat[r * ca + k]) * longint'(b_mat[k * cb + c]));
                  e.value = saturate(acc >>> mae_pkg::FRAC_BITS, ovf);
               end
               mae_pkg::OP_ADD:  e.value = saturate(128'(a + b_mat[r * ca + c]), ovf);
               mae_pkg::OP_SUB:  e.value = saturate(128'(a - b_mat[r * ca + c]), ovf);
               mae_pkg::OP_ADDS: e.value = saturate(128'(a + s), ovf);
               mae_pkg::OP_SUBS: e.value = saturate(128'(a - s), ovf);
               mae_pkg::OP_MULS: begin
                  acc = 128'(a * s);
                  e.value = saturate(acc >>> mae_pkg::FRAC_BITS, ovf);
               end
               mae_pkg::OP_DIVS: begin
                  if (s == 0) begin
                     e.value = (a >= 0) ? mae_pkg::Q_MAX : mae_pkg::Q_MIN;
                     e.status = mae_pkg::STATUS_DIVZERO;
                  end else begin
                     e.value = saturate(128'((a <<< mae_pkg::FRAC_BITS) / s), ovf);
                  end
               end
               default: e.value = a[31:0];
            endcase
            if (ovf && e.status == mae_pkg::STATUS_OK) e.status = mae_pkg::STATUS_OVERFLOW;
            cnt++;
            e.last = (cnt == orows * ocols);
            result_fifo.push_back(e);
         end
      end
   endtask

   assign pending = result_fifo.size();

   always @(posedge clock) begin
      int na, nb, total;
      elem_beat_type x;
      if (reset) begin
         op_reg = mae_pkg::OP_MUL; ra_reg = 1; ca_reg = 1; rb_reg = 1; cb_reg = 1;
         scalar_reg = 0; loaded = 0;
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (result_fifo.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result beat: value %h last %b status %0d",
                           rsp_result_element, rsp_last_result, rsp_status);
            end else begin
               x = result_fifo.pop_front();
               if (x.value !== rsp_result_element || x.last !== rsp_last_result ||
                   x.status !== rsp_status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp %h/%b/%0d got %h/%b/%0d", x.value, x.last,
                              x.status, rsp_result_element, rsp_last_result, rsp_status);
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               mae_pkg::REG_OPERATION: op_reg = csr_write_data[2:0];
               mae_pkg::REG_ROWS_A:    ra_reg = csr_write_data[3:0];
               mae_pkg::REG_COLS_A:    ca_reg = csr_write_data[3:0];
               mae_pkg::REG_ROWS_B:    rb_reg = csr_write_data[3:0];
               mae_pkg::REG_COLS_B:    cb_reg = csr_write_data[3:0];
               mae_pkg::REG_SCALAR:    scalar_reg = csr_write_data;
               default: ;
            endcase
            if (csr_index <= mae_pkg::REG_SCALAR) loaded = 0;
         end else if (start && !busy) begin
            na = dim_of(ra_reg) * dim_of(ca_reg);
            nb = dim_of(rb_reg) * dim_of(cb_reg);
            total = (op_reg <= mae_pkg::OP_SUB) ? na + nb : na;
            if (loaded < na) a_mat[loaded] = req_element;
            else if (loaded - na < nb) b_mat[loaded - na] = req_element;
            loaded++;
            if (loaded >= total) begin
               loaded = 0;
               push_results();
            end
         end
      end
   end

endmodule

// ===== tb/testbench.sv =====
module testbench;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_element = '0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_result_element;
   logic               rsp_last_result;
   logic [1:0]         rsp_status;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_write_data = '0;
   int                 fail_count;
   int                 pending;
   bit                 quiet = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   matrix_arithmetic_engine u_dut (.*);

   result_checker u_checker (.*);

   task automatic wait_drained();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic set_mode(input logic [2:0] op, input logic [3:0] ra, ca, rb, cb,
                           input logic [31:0] s);
      wait_drained();
      write_reg(mae_pkg::REG_OPERATION, 32'(op));
      write_reg(mae_pkg::REG_ROWS_A, 32'(ra));
      write_reg(mae_pkg::REG_COLS_A, 32'(ca));
      write_reg(mae_pkg::REG_ROWS_B, 32'(rb));
      write_reg(mae_pkg::REG_COLS_B, 32'(cb));
      write_reg(mae_pkg::REG_SCALAR, s);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [31:0] pick_element();
      case ($urandom_range(0, 7))
         0: return mae_pkg::Q_MAX;
         1: return mae_pkg::Q_MIN;
         2: return 32'(signed'($urandom_range(0, 8)) - 4) <<< 16;
         3: return 32'(signed'($urandom_range(0, 4000)) - 2000);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_beat(input logic [31:0] v);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start       <= 1'b1;
      req_element <= v;
      @(posedge clock iff !busy);
   endtask

   // one operation with the given shape, nsets full operand loads
   task automatic run_op(input logic [2:0] op, input logic [3:0] ra, ca, rb, cb,
                         input logic [31:0] s, input int nsets);
      int n;
      set_mode(op, ra, ca, rb, cb, s);
      n = ((ra == 0) ? 1 : (ra > mae_pkg::MAX_DIM ? mae_pkg::MAX_DIM : ra)) *
          ((ca == 0) ? 1 : (ca > mae_pkg::MAX_DIM ? mae_pkg::MAX_DIM : ca));
      if (op <= mae_pkg::OP_SUB)
         n += ((rb == 0) ? 1 : (rb > mae_pkg::MAX_DIM ? mae_pkg::MAX_DIM : rb)) *
              ((cb == 0) ? 1 : (cb > mae_pkg::MAX_DIM ? mae_pkg::MAX_DIM : cb));
      for (int i = 0; i < n * nsets; i++) send_beat(pick_element());
      start <= 1'b0;
   endtask

   initial begin
      logic [2:0] op;
      logic [3:0] ra, ca, rb, cb;
      int t;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset defaults: 1x1 multiply
      send_beat(mae_pkg::Q_MAX);
      start <= 1'b0;
      run_op(mae_pkg::OP_MUL, 2, 2, 2, 1, 0, 1);
      run_op(mae_pkg::OP_MUL, 2, 3, 2, 2, 0, 1);          // inner dimensions disagree
      run_op(mae_pkg::OP_ADD, 1, 2, 1, 2, 0, 1);
      run_op(mae_pkg::OP_SUB, 2, 1, 1, 2, 0, 1);          // shapes disagree
      run_op(mae_pkg::OP_ADDS, 0, 15, 1, 1, mae_pkg::Q_MAX, 1); // dims 0 and above max clamp
      run_op(mae_pkg::OP_SUBS, 1, 2, 1, 1, mae_pkg::Q_MIN, 1);
      run_op(mae_pkg::OP_MULS, 2, 1, 1, 1, 32'hFFFF_0000, 1);
      run_op(mae_pkg::OP_DIVS, 1, 2, 1, 1, 0, 1);         // divide by zero
      run_op(mae_pkg::OP_DIVS, 1, 2, 1, 1, 32'h0000_0001, 1);
      run_op(mae_pkg::OP_TRAN, 2, 3, 1, 1, 0, 1);
      run_op(mae_pkg::OP_MUL, 1, 8, 8, 1, 0, 1);          // longest dot product
      run_op(mae_pkg::OP_MUL, 8, 1, 1, 8, 0, 1);          // largest result matrix
      t = 0;
      while (t < 24) begin
         op = 3'($urandom_range(0, 7));
         ra = 4'($urandom_range(1, 3)); ca = 4'($urandom_range(1, 3));
         rb = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(1, 3)) :
              (op == mae_pkg::OP_MUL ? ca : ra);
         cb = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(1, 3)) :
              (op == mae_pkg::OP_MUL ? 4'($urandom_range(1, 3)) : ca);
         if (t > 16) quiet = 1'b1;
         run_op(op, ra, ca, rb, cb,
                ($urandom_range(0, 5) == 0) ? 32'h0 : pick_element(), 2);
         t += 2 * ra * ca;
      end
      @(posedge clock);
      t = 0;
      while (pending != 0 && t < 200000) begin
         @(posedge clock);
         t++;
      end
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #8000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/mae_pkg.sv
sv/mae_ram.sv
sv/mae_div.sv
sv/matrix_arithmetic_engine.sv
tb/result_checker.sv
tb/testbench.sv
